// ===== src/dkr_pkg.sv =====
// Shared types, constants and a helper function for the keyed-removal deque.
package dkr_pkg;

   localparam int Depth      = 16;
   localparam int IdBits     = 24;
   localparam int RecordBits = 32;
   localparam int PtrBits    = $clog2(Depth);
   localparam int CountBits  = $clog2(Depth + 1);

   typedef logic [PtrBits-1:0]    ptr_type;
   typedef logic [CountBits-1:0]  count_type;
   typedef logic [IdBits-1:0]     id_type;
   typedef logic [RecordBits-1:0] record_type;

   typedef enum logic [1:0] {
      MODE_PUSH_BACK  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_REMOVE_KEY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      id_type     id;
      record_type record;
   } entry_type;

   typedef struct packed {
      mode_type   mode;
      id_type     student_id;
      record_type student_record;
   } req_type;

   typedef struct packed {
      status_type status;
      id_type     removed_id;
      record_type removed_record;
      id_type     front_id;
      record_type front_record;
      logic       is_empty;
      count_type  entry_count;
   } rsp_type;

   typedef struct packed {
      logic      en;
      ptr_type   addr;
      entry_type data;
   } mem_wr_type;

   // Physical slot of logical position pos in the ring that starts at head.
   function automatic ptr_type slot_addr(ptr_type head, count_type pos);
      logic [CountBits:0] sum;
      sum = (CountBits + 1)'(head) + (CountBits + 1)'(pos);
      if (sum >= (CountBits + 1)'(Depth)) begin
         sum = sum - (CountBits + 1)'(Depth);
      end
      return sum[PtrBits-1:0];
   endfunction

endpackage

// ===== src/deque_with_keyed_removal.sv =====
// Top level of the deque with keyed removal: sequencer plus entry memory.
//
// Entries live in a ring in one memory with a registered read; the block takes one
// command at a time (start while busy is low) and drives rsp_valid for exactly one
// cycle with the result, which the receiver cannot hold off. A push, or a pop or
// remove refused because the store is full or empty, passes ST_FRONT_RD and
// ST_FRONT_WAIT before its result; a pop front first passes ST_POP_WAIT. Remove
// by key reads one entry a cycle from the front until it matches, then copies
// each later entry down one slot a cycle, then reads the new front for the result.
// The single memory read port sets this pace. busy drops in the cycle the
// result is shown, so the next command can start then.
module deque_with_keyed_removal import dkr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   mem_wr_type mem_wr;
   ptr_type    mem_rd_addr;
   entry_type  mem_rd_data;

   dkr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .mem_wr      (mem_wr),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   dkr_mem u_mem (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== src/dkr_mem.sv =====
// Entry memory: one write port, one read port with registered read data.
module dkr_mem import dkr_pkg::*; (
   input  logic       clock,
   input  mem_wr_type mem_wr,
   input  ptr_type    rd_addr,
   output entry_type  rd_data
);

   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dkr_seq.sv =====
// Command sequencer: ring pointers, key scan, gap closing and result build.
module dkr_seq import dkr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_item,
   output mem_wr_type mem_wr,
   output ptr_type    mem_rd_addr,
   input  entry_type  mem_rd_data,
   output logic       rsp_valid,
   output rsp_type    rsp_item
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_POP_WAIT   = 6'b000010,
      ST_SCAN       = 6'b000100,
      ST_SHIFT      = 6'b001000,
      ST_FRONT_RD   = 6'b010000,
      ST_FRONT_WAIT = 6'b100000
   } state_type;

   state_type  state_ff,     state_in;
   ptr_type    head_ff,      head_in;
   count_type  count_ff,     count_in;
   count_type  idx_ff,       idx_in;
   req_type    cmd_ff,       cmd_in;
   status_type status_ff,    status_in;
   entry_type  removed_ff,   removed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_item_ff,  rsp_item_in;

   ptr_type    head_dec;
   count_type  idx_next;

   assign head_dec = (head_ff == '0) ? ptr_type'(Depth - 1) : head_ff - ptr_type'(1);
   assign idx_next = idx_ff + count_type'(1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = head_ff;
      mem_wr.data  = mem_rd_data;
      mem_rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_item;
               status_in  = STATUS_OK;
               removed_in = '0;
               idx_in     = '0;
               state_in   = ST_FRONT_RD;
               unique case (req_item.mode)
                  MODE_PUSH_BACK: begin
                     if (count_ff == count_type'(Depth)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = slot_addr(head_ff, count_ff);
                        mem_wr.data = {req_item.student_id, req_item.student_record};
                        count_in    = count_ff + count_type'(1);
                     end
                  end
                  MODE_PUSH_FRONT: begin
                     if (count_ff == count_type'(Depth)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = head_dec;
                        mem_wr.data = {req_item.student_id, req_item.student_record};
                        head_in     = head_dec;
                        count_in    = count_ff + count_type'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP_WAIT;
                     end
                  end
                  MODE_REMOVE_KEY: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: state_in = ST_FRONT_RD;
               endcase
            end
         end
         ST_POP_WAIT: begin
            removed_in = mem_rd_data;
            head_in    = slot_addr(head_ff, count_type'(1));
            count_in   = count_ff - count_type'(1);
            state_in   = ST_FRONT_RD;
         end
         ST_SCAN: begin
            if (mem_rd_data.id == cmd_ff.student_id) begin
               removed_in = mem_rd_data;
               if (idx_next < count_ff) begin
                  // fetch the successor to slide into the gap
                  mem_rd_addr = slot_addr(head_ff, idx_next);
                  state_in    = ST_SHIFT;
               end else begin
                  count_in = count_ff - count_type'(1);
                  state_in = ST_FRONT_RD;
               end
            end else if (idx_next < count_ff) begin
               idx_in      = idx_next;
               mem_rd_addr = slot_addr(head_ff, idx_next);
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FRONT_RD;
            end
         end
         ST_SHIFT: begin
            // move entry idx+1 down to idx, prefetch idx+2
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_addr(head_ff, idx_ff);
            mem_wr.data = mem_rd_data;
            idx_in      = idx_next;
            mem_rd_addr = slot_addr(head_ff, idx_next + count_type'(1));
            if (idx_next >= count_ff - count_type'(1)) begin
               count_in = count_ff - count_type'(1);
               state_in = ST_FRONT_RD;
            end
         end
         ST_FRONT_RD: begin
            mem_rd_addr = head_ff;
            state_in    = ST_FRONT_WAIT;
         end
         ST_FRONT_WAIT: begin
            rsp_valid_in               = 1'b1;
            rsp_item_in.status         = status_ff;
            rsp_item_in.removed_id     = removed_ff.id;
            rsp_item_in.removed_record = removed_ff.record;
            rsp_item_in.front_id       = (count_ff != '0) ? mem_rd_data.id : '0;
            rsp_item_in.front_record   = (count_ff != '0) ? mem_rd_data.record : '0;
            rsp_item_in.is_empty       = (count_ff == '0);
            rsp_item_in.entry_count    = count_ff;
            state_in                   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(Depth))
      else $error("entry count above depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SHIFT) |-> idx_ff < count_ff)
      else $error("scan index past last entry");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FRONT_WAIT |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not issued after front read");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_no_write_late: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRONT_RD || state_ff == ST_FRONT_WAIT) |-> !mem_wr.en)
      else $error("memory written during front read");

endmodule
